>>> design/mnfr_pkg.sv
package mnfr_pkg;

    localparam int TILE_ELEMS = 64;
    localparam int TILE_COLS  = 8;
    localparam int KIND_W     = 4;
    localparam int KIND_CODES = 1 << KIND_W;
    localparam int USER_W     = KIND_W + 1;
    localparam int NO_SOURCE  = -1;

    typedef logic [TILE_ELEMS-1:0] t_tile;
    typedef logic [KIND_W-1:0]     t_kind_code;

    typedef enum logic [KIND_W-1:0] {
        KIND_L1 = 4'd0,
        KIND_R1 = 4'd1,
        KIND_U1 = 4'd2,
        KIND_D1 = 4'd3,
        KIND_L2 = 4'd4,
        KIND_R2 = 4'd5,
        KIND_U2 = 4'd6,
        KIND_D2 = 4'd7,
        KIND_L4 = 4'd8,
        KIND_R4 = 4'd9,
        KIND_U4 = 4'd10,
        KIND_D4 = 4'd11
    } t_kind;

    function automatic int mesh_source(int k, int i);
        int r;
        int c;
        int s;
        r = i / TILE_COLS;
        c = i % TILE_COLS;
        s = NO_SOURCE;
        case (k)
            int'(KIND_L1): s = (i == 0) ? NO_SOURCE : i - 1;
            int'(KIND_R1): s = (i == 63) ? NO_SOURCE : i + 1;
            int'(KIND_U1): s = (r == 0) ? NO_SOURCE : i - 8;
            int'(KIND_D1): s = (i >= 56) ? NO_SOURCE : i + 8;
            int'(KIND_L2): begin
                if (i == 0)      s = NO_SOURCE;
                else if (c > 4)  s = i + 4 - c;
                else if (c == 0) s = i - 4;
                else             s = i - c;
            end
            int'(KIND_R2): begin
                if (i > 61)              s = NO_SOURCE;
                else if (c > 1 && c < 6) s = i - c + 6;
                else if (c > 5)          s = i - c + 10;
                else                     s = i - c + 2;
            end
            int'(KIND_U2): s = (r == 0) ? NO_SOURCE : ((r < 5) ? c : 32 + c);
            int'(KIND_D2): begin
                if (r > 5)      s = NO_SOURCE;
                else if (r < 2) s = i + 8 * (2 - r);
                else            s = i + 8 * (6 - r);
            end
            int'(KIND_L4): begin
                if (i == 0)      s = NO_SOURCE;
                else if (c == 0) s = i - 8;
                else             s = i - c;
            end
            int'(KIND_R4): begin
                if (i > 59)     s = NO_SOURCE;
                else if (c < 4) s = i - c + 4;
                else            s = i - c + 12;
            end
            int'(KIND_U4): s = (r == 0) ? NO_SOURCE : c;
            int'(KIND_D4): s = (r > 3) ? NO_SOURCE : i + 8 * (4 - r);
            default:       s = NO_SOURCE;
        endcase
        return s;
    endfunction

endpackage

>>> design/mnfr_route.sv
module mnfr_route (
    input  mnfr_pkg::t_tile      i_sign_bits,
    input  mnfr_pkg::t_kind_code i_kind,
    input  logic                 i_invert,
    output mnfr_pkg::t_tile      o_flags
);

    for (genvar gi = 0; gi < mnfr_pkg::TILE_ELEMS; gi++) begin : g_elem
        logic [mnfr_pkg::KIND_CODES-1:0] w_cand;

        for (genvar gk = 0; gk < mnfr_pkg::KIND_CODES; gk++) begin : g_kind
            localparam int Src = mnfr_pkg::mesh_source(gk, gi);
            if (Src >= 0 && Src < mnfr_pkg::TILE_ELEMS) begin : g_src
                assign w_cand[gk] = i_sign_bits[Src] ^ i_invert;
            end else if (gk <= int'(mnfr_pkg::KIND_D4)) begin : g_edge
                assign w_cand[gk] = i_invert;
            end else begin : g_undef
                assign w_cand[gk] = 1'b0;
            end
        end

        assign o_flags[gi] = w_cand[i_kind];
    end

endmodule

>>> design/mesh_neighbor_flag_router.sv
// An accepted input word passes the input register, routing mux and result register
// to the master side; one word per cycle while the master side accepts words.
// Backpressure on the master side stalls both registers; s_axis_tready drops only
// when both hold a word.
// Reset (i_rst_n low, synchronous) empties both stages; no other state.
module mesh_neighbor_flag_router (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,  // [63:0] sign_bits
    input  logic [mnfr_pkg::USER_W-1:0]  s_axis_tuser,  // [3:0] kind, [4] invert
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [63:0]                  m_axis_tdata   // [63:0] flags
);

    logic                 r_in_vld;
    mnfr_pkg::t_tile      r_sign;
    mnfr_pkg::t_kind_code r_kind;
    logic                 r_inv;
    logic                 r_out_vld;
    mnfr_pkg::t_tile      r_flags;
    mnfr_pkg::t_tile      n_flags;
    logic                 w_out_rdy;
    logic                 w_in_rdy;

    assign w_out_rdy     = !r_out_vld || m_axis_tready;
    assign w_in_rdy      = !r_in_vld || w_out_rdy;
    assign s_axis_tready = w_in_rdy;

    mnfr_route u_route (
        .i_sign_bits (r_sign),
        .i_kind      (r_kind),
        .i_invert    (r_inv),
        .o_flags     (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_rdy) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_out_rdy) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_rdy && s_axis_tvalid) begin
            r_sign <= s_axis_tdata;
            r_kind <= s_axis_tuser[mnfr_pkg::KIND_W-1:0];
            r_inv  <= s_axis_tuser[mnfr_pkg::KIND_W];
        end
        if (w_out_rdy && r_in_vld) begin
            r_flags <= n_flags;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_flags;

endmodule

>>> design/mnfr_checker.sv
module mnfr_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,
    input  logic [mnfr_pkg::USER_W-1:0]  s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [63:0]                  m_axis_tdata
);

    logic w_s_acc;
    logic w_undef;

    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_undef = s_axis_tuser[3] && s_axis_tuser[2];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result word missing two cycles after input");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && w_undef ##1 m_axis_tready |=> m_axis_tdata == 64'd0)
        else $error("undefined operation gave nonzero flags");

endmodule

bind mesh_neighbor_flag_router mnfr_checker u_mnfr_checker (.*);
